>>> rtl/wfl_pkg.sv
//------------------------------------------------------------------------------
// wfl_pkg
// Shared types and constants for the right-hand wall follower.
//------------------------------------------------------------------------------
`default_nettype none

package wfl_pkg;

	localparam int GRID_SIZE = 16;
	localparam int RW        = $clog2(GRID_SIZE);
	localparam int FW        = 4;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	typedef logic [RW-1:0]        idx_t;
	typedef logic [GRID_SIZE-1:0] row_t;
	typedef logic [FW-1:0]        coord_t;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] HD_EAST  = 2'd0;
	localparam logic [1:0] HD_SOUTH = 2'd1;
	localparam logic [1:0] HD_WEST  = 2'd2;
	localparam logic [1:0] HD_NORTH = 2'd3;

	localparam logic REG_END_ROW   = 1'b0;
	localparam logic REG_START_ROW = 1'b1;

	localparam coord_t END_ROW_RST   = 4'd1;
	localparam coord_t START_ROW_RST = 4'd1;

	typedef struct packed {
		coord_t end_row;
		coord_t start_row;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/wfl_ram.sv
//------------------------------------------------------------------------------
// wfl_ram
// Generic RAM: one write port, two registered read ports.
//------------------------------------------------------------------------------
`default_nettype none

module wfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic [WIDTH-1:0]         ra_data,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

`default_nettype wire

>>> rtl/wfl_cfg.sv
//------------------------------------------------------------------------------
// wfl_cfg
// APB register file: exit row and entry row.
//------------------------------------------------------------------------------
`default_nettype none

module wfl_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfl_pkg::APB_AW-1:0]  paddr,
	input  logic [wfl_pkg::APB_DW-1:0]  pwdata,
	output logic [wfl_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output wfl_pkg::cfg_t               cfg
);
	import wfl_pkg::*;

	logic   reg_sel;
	logic   wr_en;
	coord_t end_row_q;
	coord_t start_row_q;

	// registers sit at 4-byte steps
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_row_q   <= END_ROW_RST;
			start_row_q <= START_ROW_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_END_ROW:   end_row_q   <= pwdata[FW-1:0];
				REG_START_ROW: start_row_q <= pwdata[FW-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_END_ROW:   prdata = APB_DW'(end_row_q);
			REG_START_ROW: prdata = APB_DW'(start_row_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.end_row   = end_row_q;
	assign cfg.start_row = start_row_q;

endmodule

`default_nettype wire

>>> rtl/right_hand_wall_follower_top.sv
//------------------------------------------------------------------------------
// right_hand_wall_follower_top
// Grid maze walker following the right-hand wall, map kept in a row-wide RAM.
//------------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready) takes one item: load a map cell,
//   place the walker at the entry, or take one step. Every item returns one
//   item on the result channel (res_valid/res_ready) with the walker position,
//   heading, a moved flag and the arrived flag.
//   The map is one RAM row per grid row, read on two registered ports. Work
//   per item, from acceptance to result register:
//     start / unused command : done on acceptance
//     load                   : read row, write back modified row
//     step                   : read rows r and r+1, then row r-1, then decide
//   The next item is taken once the current one is finished; a result that
//   waits in the output register does not block the next item's work, only
//   its completion.
//   Reset clears the walker to row 0, column 0, facing east, arrived low,
//   and loads exit row 1 and entry row 1. Map contents are undefined until
//   loaded; load every cell before stepping. The user must write registers
//   over APB only while the block is idle; the block does not enforce this.
//------------------------------------------------------------------------------
`default_nettype none

module right_hand_wall_follower_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wfl_pkg::APB_AW-1:0]  paddr,
	input  logic [wfl_pkg::APB_DW-1:0]  pwdata,
	output logic [wfl_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	// command channel
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [1:0]                  command,
	input  logic [wfl_pkg::FW-1:0]      cell_row,
	input  logic [wfl_pkg::FW-1:0]      cell_col,
	input  logic                        cell_open,
	// result channel
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [wfl_pkg::FW-1:0]      walker_row,
	output logic [wfl_pkg::FW-1:0]      walker_col,
	output logic [1:0]                  heading,
	output logic                        moved,
	output logic                        arrived
);
	import wfl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LDWR = 5'b00010,
		ST_STRD = 5'b00100,
		ST_STEV = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	function automatic logic at_exit(idx_t r, idx_t c, coord_t er);
		return (32'(r) == 32'(er)) && (32'(c) == GRID_SIZE - 1);
	endfunction

	cfg_t   cfg;
	state_t state_q, state_d;

	idx_t       cur_row_q, cur_col_q;
	logic [1:0] head_q;
	logic       done_q, moved_q;

	idx_t ld_row_q, ld_col_q;
	logic ld_open_q, ld_ok_q;

	row_t row_cur_s1, row_dn_s1;

	logic       out_valid_q;
	coord_t     o_row_q, o_col_q;
	logic [1:0] o_head_q;
	logic       o_moved_q, o_arr_q;

	logic cmd_acc, out_free, fin;
	idx_t ra_addr, rb_addr;
	row_t ra_data, rb_data, wr_row;
	logic ram_we;

	idx_t       nxt_row, nxt_col;
	logic [1:0] nxt_head;
	logic       nxt_done, nxt_moved;

	idx_t       start_idx;
	logic [3:0] dir_open;
	logic [1:0] h_r, h_s, h_l, h_sel;
	logic       go;
	idx_t       mv_row, mv_col;

	wfl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wfl_ram #(
		.WIDTH (GRID_SIZE),
		.DEPTH (GRID_SIZE)
	) u_map (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ld_row_q),
		.wdata   (wr_row),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_addr (rb_addr),
		.rb_data (rb_data)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign out_free  = !out_valid_q || res_ready;

	// port A: own row (or row to load), port B: row below, then row above
	assign ra_addr = (command == CMD_LOAD) ? RW'(cell_row) : cur_row_q;
	assign rb_addr = (state_q == ST_IDLE) ? RW'(cur_row_q + 1'b1) : RW'(cur_row_q - 1'b1);

	always_comb begin
		wr_row           = ra_data;
		wr_row[ld_col_q] = ld_open_q;
	end
	assign ram_we = (state_q == ST_LDWR) && ld_ok_q;

	assign start_idx = (32'(cfg.start_row) > GRID_SIZE - 1) ? idx_t'(GRID_SIZE - 1)
		: RW'(cfg.start_row);

	// neighbor lookup; out-of-grid cells are walls
	always_comb begin
		dir_open[HD_EAST]  = (32'(cur_col_q) < GRID_SIZE - 1)
			&& row_cur_s1[RW'(cur_col_q + 1'b1)];
		dir_open[HD_SOUTH] = (32'(cur_row_q) < GRID_SIZE - 1) && row_dn_s1[cur_col_q];
		dir_open[HD_WEST]  = (cur_col_q != '0) && row_cur_s1[RW'(cur_col_q - 1'b1)];
		dir_open[HD_NORTH] = (cur_row_q != '0) && rb_data[cur_col_q];
	end

	assign h_r = 2'(head_q + 2'd1);
	assign h_s = head_q;
	assign h_l = 2'(head_q + 2'd3);

	always_comb begin
		go    = 1'b1;
		h_sel = h_s;
		priority if (dir_open[h_r]) begin
			h_sel = h_r;
		end else if (dir_open[h_s]) begin
			h_sel = h_s;
		end else if (dir_open[h_l]) begin
			h_sel = h_l;
		end else begin
			go = 1'b0;
		end
	end

	always_comb begin
		mv_row = cur_row_q;
		mv_col = cur_col_q;
		unique case (h_sel)
			HD_EAST:  mv_col = RW'(cur_col_q + 1'b1);
			HD_SOUTH: mv_row = RW'(cur_row_q + 1'b1);
			HD_WEST:  mv_col = RW'(cur_col_q - 1'b1);
			HD_NORTH: mv_row = RW'(cur_row_q - 1'b1);
			default:  ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		fin       = 1'b0;
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		nxt_head  = head_q;
		nxt_done  = done_q;
		nxt_moved = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					priority if (command == CMD_LOAD) begin
						state_d = ST_LDWR;
					end else if (command == CMD_STEP) begin
						state_d = ST_STRD;
					end else begin
						fin = 1'b1;
						if (command == CMD_START) begin
							nxt_row  = start_idx;
							nxt_col  = '0;
							nxt_head = HD_EAST;
							nxt_done = at_exit(start_idx, '0, cfg.end_row);
						end
					end
				end
			end
			ST_LDWR: fin = 1'b1;
			ST_STRD: state_d = ST_STEV;
			ST_STEV: begin
				fin = 1'b1;
				if (!done_q) begin
					if (go) begin
						nxt_row   = mv_row;
						nxt_col   = mv_col;
						nxt_head  = h_sel;
						nxt_moved = 1'b1;
						nxt_done  = at_exit(mv_row, mv_col, cfg.end_row);
					end else begin
						nxt_head = 2'(head_q + 2'd2);
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			head_q      <= HD_EAST;
			done_q      <= 1'b0;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				cur_row_q <= nxt_row;
				cur_col_q <= nxt_col;
				head_q    <= nxt_head;
				done_q    <= nxt_done;
				moved_q   <= nxt_moved;
			end
			if ((fin || state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			ld_row_q  <= RW'(cell_row);
			ld_col_q  <= RW'(cell_col);
			ld_open_q <= cell_open;
			ld_ok_q   <= (32'(cell_row) < GRID_SIZE) && (32'(cell_col) < GRID_SIZE);
		end
		if (state_q == ST_STRD) begin
			row_cur_s1 <= ra_data;
			row_dn_s1  <= rb_data;
		end
		if (fin && out_free) begin
			o_row_q   <= FW'(nxt_row);
			o_col_q   <= FW'(nxt_col);
			o_head_q  <= nxt_head;
			o_moved_q <= nxt_moved;
			o_arr_q   <= nxt_done;
		end else if (state_q == ST_HOLD && out_free) begin
			o_row_q   <= FW'(cur_row_q);
			o_col_q   <= FW'(cur_col_q);
			o_head_q  <= head_q;
			o_moved_q <= moved_q;
			o_arr_q   <= done_q;
		end
	end

	assign res_valid  = out_valid_q;
	assign walker_row = o_row_q;
	assign walker_col = o_col_q;
	assign heading    = o_head_q;
	assign moved      = o_moved_q;
	assign arrived    = o_arr_q;

	a_we_only_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_LDWR)
		else $error("map written outside load write-back");

	a_step_reads_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && command == CMD_STEP) |=> state_q == ST_STRD ##1 state_q == ST_STEV)
		else $error("step did not take its two read cycles");

	a_no_move_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEV && done_q) |-> !nxt_moved && nxt_done)
		else $error("walker moved after arrival");

	a_hold_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> out_valid_q)
		else $error("waiting on output with empty result register");

	a_move_is_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && nxt_moved) |-> ((nxt_row == cur_row_q) != (nxt_col == cur_col_q)))
		else $error("step moved by other than one cell");

endmodule

`default_nettype wire

>>> tb/wfl_tb_pkg.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// wfl_tb_pkg
// Walker predictor and result scoreboard for the wall follower testbench.
//------------------------------------------------------------------------------
package wfl_tb_pkg;
	import wfl_pkg::*;

	typedef struct packed {
		coord_t     row;
		coord_t     col;
		logic [1:0] hd;
		logic       moved;
		logic       arrived;
	} walker_pos_t;

	class walker_scoreboard;
		bit          open_map[GRID_SIZE][GRID_SIZE];
		coord_t      pos_row;
		coord_t      pos_col;
		logic [1:0]  pos_hd;
		bit          done;
		coord_t      exit_row;
		coord_t      entry_row;
		walker_pos_t expected_positions[$];
		int          errors;
		int          checked;
		int          steps;
		int          moves;
		int          arrivals;

		function new();
			pos_row   = '0;
			pos_col   = '0;
			pos_hd    = HD_EAST;
			done      = 1'b0;
			exit_row  = END_ROW_RST;
			entry_row = START_ROW_RST;
			errors    = 0;
			checked   = 0;
			steps     = 0;
			moves     = 0;
			arrivals  = 0;
		endfunction

		function void log_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		function void set_register(logic idx, coord_t val);
			if (idx == REG_END_ROW)
				exit_row = val;
			else
				entry_row = val;
		endfunction

		function void check_register(logic idx, coord_t got);
			coord_t want;
			want = (idx == REG_END_ROW) ? exit_row : entry_row;
			if (got !== want)
				log_error($sformatf("register %0d readback: expected %0d, got %0d",
					idx, want, got));
		endfunction

		// anything off the grid is a wall
		function bit is_open(int r, int c);
			if (r < 0 || c < 0 || r >= GRID_SIZE || c >= GRID_SIZE)
				return 1'b0;
			return open_map[r][c];
		endfunction

		function bit at_exit();
			return int'(pos_row) == int'(exit_row) && int'(pos_col) == GRID_SIZE - 1;
		endfunction

		function void take_command(logic [1:0] cmd, coord_t r, coord_t c, logic op);
			walker_pos_t nxt;
			logic [1:0]  h;
			int          nr;
			int          nc;
			int          k;
			bit          went;
			nxt.moved = 1'b0;
			case (cmd)
				CMD_LOAD: begin
					if (int'(r) < GRID_SIZE && int'(c) < GRID_SIZE)
						open_map[r][c] = op;
				end
				CMD_START: begin
					pos_row = (int'(entry_row) > GRID_SIZE - 1) ?
						coord_t'(GRID_SIZE - 1) : entry_row;
					pos_col = '0;
					pos_hd  = HD_EAST;
					done    = at_exit();
				end
				CMD_STEP: begin
					steps++;
					if (!done) begin
						went = 1'b0;
						// k = 0, 1, 2 tries right (+1), straight (+0), left (+3)
						for (k = 0; k < 3 && !went; k++) begin
							h  = pos_hd + 2'(5 - k);
							nr = int'(pos_row);
							nc = int'(pos_col);
							case (h)
								HD_EAST:  nc++;
								HD_SOUTH: nr++;
								HD_WEST:  nc--;
								default:  nr--;
							endcase
							if (is_open(nr, nc)) begin
								pos_row = coord_t'(nr);
								pos_col = coord_t'(nc);
								pos_hd  = h;
								went    = 1'b1;
							end
						end
						if (went) begin
							nxt.moved = 1'b1;
							moves++;
							done = at_exit();
							if (done)
								arrivals++;
						end else begin
							pos_hd = pos_hd + 2'd2;
						end
					end
				end
				default: ;
			endcase
			nxt.row     = pos_row;
			nxt.col     = pos_col;
			nxt.hd      = pos_hd;
			nxt.arrived = done;
			expected_positions.push_back(nxt);
		endfunction

		function void check_position(walker_pos_t got);
			walker_pos_t want;
			if (expected_positions.size() == 0) begin
				log_error($sformatf("result with nothing pending: row %0d col %0d hd %0d",
					got.row, got.col, got.hd));
				return;
			end
			want = expected_positions.pop_front();
			checked++;
			if (got.row !== want.row || got.col !== want.col || got.hd !== want.hd ||
					got.moved !== want.moved || got.arrived !== want.arrived)
				log_error($sformatf({"result %0d: expected row %0d col %0d hd %0d moved %0d ",
					"arrived %0d, got row %0d col %0d hd %0d moved %0d arrived %0d"},
					checked, want.row, want.col, want.hd, want.moved, want.arrived,
					got.row, got.col, got.hd, got.moved, got.arrived));
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Drives map loads, start, step and no-op commands into the wall follower with
// random idle bursts on both channels, sweeps the entry and exit rows over APB,
// and checks every result item against a cycle-free model of the walker.
//------------------------------------------------------------------------------
module tb_top;
	import wfl_pkg::*;
	import wfl_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT_ITEM = 345;
	localparam int HOLD_CYCLES  = 60;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	logic [1:0]        command   = CMD_NOP;
	coord_t            cell_row  = '0;
	coord_t            cell_col  = '0;
	logic              cell_open = 1'b0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	coord_t            walker_row;
	coord_t            walker_col;
	logic [1:0]        heading;
	logic              moved;
	logic              arrived;

	walker_scoreboard walk_sb = new();
	int               items_in = 0;
	int               cycles   = 0;
	bit               calm     = 1'b0;

	always #2 clk = ~clk;

	right_hand_wall_follower_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_open  (cell_open),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.walker_row (walker_row),
		.walker_col (walker_col),
		.heading    (heading),
		.moved      (moved),
		.arrived    (arrived)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random ready bursts plus one long hold-off to back up the block
	initial begin : result_sink
		int          burst_left;
		int          hold_left;
		bit          held;
		walker_pos_t got;
		burst_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_ready) begin
				got.row     = walker_row;
				got.col     = walker_col;
				got.hd      = heading;
				got.moved   = moved;
				got.arrived = arrived;
				walk_sb.check_position(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!held && items_in >= HOLD_AT_ITEM) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				res_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(0, 2);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// called at a rising edge; returns at the edge where the item is taken
	task automatic send_cmd(input logic [1:0] cmd, input coord_t r, input coord_t c,
			input logic op);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		cell_row  <= r;
		cell_col  <= c;
		cell_open <= op;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		walk_sb.take_command(cmd, r, c, op);
		items_in++;
	endtask

	// the cell fields are don't-care outside loads, so keep them moving
	task automatic send_rnd(input logic [1:0] cmd);
		send_cmd(cmd, coord_t'($urandom_range(0, GRID_SIZE - 1)),
			coord_t'($urandom_range(0, GRID_SIZE - 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (walk_sb.expected_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic idx, input coord_t val,
			output coord_t rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata[FW-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_register(input logic idx);
		coord_t rd;
		apb_cycle(1'b0, idx, '0, rd);
		walk_sb.check_register(idx, rd);
		@(posedge clk);
	endtask

	task automatic set_register(input logic idx, input coord_t val);
		coord_t rd;
		apb_cycle(1'b1, idx, val, rd);
		walk_sb.set_register(idx, val);
		@(posedge clk);
		read_register(idx);
	endtask

	task automatic run_phase(input coord_t exit_r, input coord_t entry_r, input int n);
		int pick;
		settle();
		set_register(REG_END_ROW, exit_r);
		set_register(REG_START_ROW, entry_r);
		send_rnd(CMD_START);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 66)
				send_rnd(CMD_STEP);
			else if (pick < 82)
				send_cmd(CMD_LOAD, coord_t'($urandom_range(0, GRID_SIZE - 1)),
					coord_t'($urandom_range(0, GRID_SIZE - 1)), ($urandom_range(0, 9) < 6));
			else if (pick < 92)
				send_rnd(CMD_START);
			else
				send_rnd(CMD_NOP);
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_register(REG_END_ROW);
		read_register(REG_START_ROW);
		send_rnd(CMD_NOP);

		// open the whole grid before anything can step
		for (int r = 0; r < GRID_SIZE; r++)
			for (int c = 0; c < GRID_SIZE; c++)
				send_cmd(CMD_LOAD, coord_t'(r), coord_t'(c), 1'b1);

		// step from the reset position, then walk the empty grid down the west
		// wall, along the bottom and up to the exit; the last few steps land
		// after arrival
		send_rnd(CMD_STEP);
		send_rnd(CMD_START);
		repeat (46) send_rnd(CMD_STEP);

		// extreme rows: entry and exit both on the bottom row
		settle();
		set_register(REG_END_ROW, coord_t'(GRID_SIZE - 1));
		set_register(REG_START_ROW, coord_t'(GRID_SIZE - 1));
		send_rnd(CMD_START);
		repeat (17) send_rnd(CMD_STEP);

		// boxed in at the top-left corner: the walker turns around twice
		settle();
		set_register(REG_START_ROW, '0);
		send_cmd(CMD_LOAD, 4'd0, 4'd1, 1'b0);
		send_cmd(CMD_LOAD, 4'd1, 4'd0, 1'b0);
		send_rnd(CMD_START);
		send_rnd(CMD_STEP);
		send_rnd(CMD_STEP);
		send_cmd(CMD_LOAD, 4'd0, 4'd1, 1'b1);
		send_cmd(CMD_LOAD, 4'd1, 4'd0, 1'b1);

		run_phase(coord_t'(GRID_SIZE - 1), '0, 29);
		run_phase('0, coord_t'(GRID_SIZE - 1), 29);
		run_phase(coord_t'($urandom_range(0, GRID_SIZE - 1)),
			coord_t'($urandom_range(0, GRID_SIZE - 1)), 29);
		settle();
		calm = 1'b1;
		run_phase(coord_t'($urandom_range(0, GRID_SIZE - 1)),
			coord_t'($urandom_range(0, GRID_SIZE - 1)), 29);

		settle();
		$display("Run covered %0d items: %0d steps, %0d moves, %0d arrivals at the exit.",
			items_in, walk_sb.steps, walk_sb.moves, walk_sb.arrivals);
		$display("Results checked: %0d, errors: %0d, rows swept to both ends.",
			walk_sb.checked, walk_sb.errors);
		if (walk_sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
